/* hw/rtl/dsf_pkg.sv */
`default_nettype none
package dsf_pkg;

    localparam int FRAC_BITS_DEF = 16;

    // Widths fixed by the word format.
    localparam int IN_W   = 32;
    localparam int REG_W  = 31;
    localparam int DIFF_W = 33;   // exact difference of two 32-bit values
    localparam int RAD_W  = 68;   // sum of two 33-bit squares, padded to one bit pair per root cell
    localparam int ROOT_W = 34;
    localparam int REM_W  = 36;
    localparam int TERM_W = 41;   // saturated intermediate terms, +-(2^40)
    localparam int PROD_W = 64;
    localparam int DREM_W = 35;   // divider partial remainder

    typedef enum logic [1:0] {
        REG_SPRING_K = 2'd0,
        REG_DAMPING  = 2'd1,
        REG_REST_LEN = 2'd2
    } reg_index_t;

    // Everything one item carries down the pipe beside the cell data.
    typedef struct packed {
        logic                     neg_x;
        logic                     neg_y;
        logic [DIFF_W-1:0]        dmag_x;
        logic [DIFF_W-1:0]        dmag_y;
        logic signed [DIFF_W-1:0] dv_x;
        logic signed [DIFF_W-1:0] dv_y;
        logic signed [TERM_W-1:0] damp_x;
        logic signed [TERM_W-1:0] damp_y;
        logic [ROOT_W-1:0]        mag;
        logic signed [TERM_W-1:0] s;
        logic                     hold;
    } side_t;

    // Signed value of a magnitude, saturated to [-2^40, 2^40-1].
    function automatic logic signed [TERM_W-1:0] sat_mag(input logic [PROD_W-1:0] m,
                                                         input logic neg);
        logic [TERM_W-1:0] lo;
        lo = m[TERM_W-1:0];
        if (neg) begin
            if (m > {{(PROD_W-TERM_W){1'b0}}, 1'b1, {(TERM_W-1){1'b0}}})
                sat_mag = {1'b1, {(TERM_W-1){1'b0}}};
            else
                sat_mag = $signed(~lo + 1'b1);
        end
        else begin
            if (m > {{(PROD_W-TERM_W+1){1'b0}}, {(TERM_W-1){1'b1}}})
                sat_mag = {1'b0, {(TERM_W-1){1'b1}}};
            else
                sat_mag = $signed(lo);
        end
    endfunction

endpackage
`default_nettype wire

/* hw/rtl/damped_spring_force_top.sv */
// Throughput: one word per cycle; the whole pipe moves as one unit and halts only
// while a finished result sits in the output register under stall.
// The pipe holds a chain of 34 square-root cells and FRAC_BITS + 1 divider cells.
// Reset clears all valid bits and loads k = 1.0, c = 0 and rest length = 1.0.
`default_nettype none
module damped_spring_force_top #(
    parameter int FRAC_BITS = dsf_pkg::FRAC_BITS_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic signed [dsf_pkg::IN_W-1:0]   a_pos_x,
    input  wire logic signed [dsf_pkg::IN_W-1:0]   a_pos_y,
    input  wire logic signed [dsf_pkg::IN_W-1:0]   b_pos_x,
    input  wire logic signed [dsf_pkg::IN_W-1:0]   b_pos_y,
    input  wire logic signed [dsf_pkg::IN_W-1:0]   a_vel_x,
    input  wire logic signed [dsf_pkg::IN_W-1:0]   a_vel_y,
    input  wire logic signed [dsf_pkg::IN_W-1:0]   b_vel_x,
    input  wire logic signed [dsf_pkg::IN_W-1:0]   b_vel_y,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic signed [dsf_pkg::IN_W-1:0]        force_x,
    output logic signed [dsf_pkg::IN_W-1:0]        force_y,
    output logic                                   applied,
    input  wire logic                              cfg_we,
    input  wire logic [1:0]                        cfg_index,
    input  wire logic [dsf_pkg::REG_W-1:0]         cfg_data
);
    // Stage map: difference stage, square/damping stage, 34 root cells, the
    // extension stage, FRAC_BITS + 1 divider cells, the spring product stage, the final stage.
    localparam int NSQ  = dsf_pkg::ROOT_W;
    localparam int QW   = FRAC_BITS + 1;
    localparam int L_E  = 2 + NSQ;
    localparam int L_D0 = L_E + 1;
    localparam int L_M  = L_D0 + QW;
    localparam int NST  = L_M + 1;
    localparam int SP_W = dsf_pkg::TERM_W + QW;

    logic [dsf_pkg::REG_W-1:0] k_reg, c_reg, rest_reg;

    dsf_pkg::side_t side_reg  [NST];
    logic [NST-1:0] valid_reg;
    logic           adv;

    dsf_pkg::side_t side_s1, side_s2, side_e;
    logic [dsf_pkg::RAD_W-1:0] sum_reg;

    // The whole pipe advances unless the output register holds a word under stall.
    assign adv      = !out_valid || !out_stall;
    assign in_stall = !adv;

    // The user must write configuration only while the block is idle; the block does not enforce this.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg    <= dsf_pkg::REG_W'(1 << 16);
            c_reg    <= '0;
            rest_reg <= dsf_pkg::REG_W'(1 << 16);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                dsf_pkg::REG_SPRING_K: k_reg    <= cfg_data;
                dsf_pkg::REG_DAMPING:  c_reg    <= cfg_data;
                dsf_pkg::REG_REST_LEN: rest_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (adv)
            valid_reg <= {valid_reg[NST-2:0], in_valid};
    end

    // First stage: exact 33-bit differences; the position ones are split into sign and magnitude.
    logic signed [dsf_pkg::DIFF_W-1:0] dx, dy;
    always_comb
    begin
        dx = $signed({a_pos_x[31], a_pos_x}) - $signed({b_pos_x[31], b_pos_x});
        dy = $signed({a_pos_y[31], a_pos_y}) - $signed({b_pos_y[31], b_pos_y});
        side_s1        = '0;
        side_s1.neg_x  = dx[dsf_pkg::DIFF_W-1];
        side_s1.neg_y  = dy[dsf_pkg::DIFF_W-1];
        side_s1.dmag_x = dx[dsf_pkg::DIFF_W-1] ? dsf_pkg::DIFF_W'(-dx) : dx;
        side_s1.dmag_y = dy[dsf_pkg::DIFF_W-1] ? dsf_pkg::DIFF_W'(-dy) : dy;
        side_s1.dv_x   = $signed({a_vel_x[31], a_vel_x}) - $signed({b_vel_x[31], b_vel_x});
        side_s1.dv_y   = $signed({a_vel_y[31], a_vel_y}) - $signed({b_vel_y[31], b_vel_y});
    end

    // Second stage: squared length and the saturated damping terms.
    logic [dsf_pkg::DIFF_W-1:0] dvm_x, dvm_y;
    logic [dsf_pkg::PROD_W-1:0] pd_x, pd_y;
    logic [dsf_pkg::RAD_W-1:0]  sum_next;
    always_comb
    begin
        side_s2  = side_reg[0];
        sum_next = side_reg[0].dmag_x * side_reg[0].dmag_x
                 + side_reg[0].dmag_y * side_reg[0].dmag_y;
        dvm_x = side_reg[0].dv_x[dsf_pkg::DIFF_W-1] ? dsf_pkg::DIFF_W'(-side_reg[0].dv_x)
                                                    : side_reg[0].dv_x;
        dvm_y = side_reg[0].dv_y[dsf_pkg::DIFF_W-1] ? dsf_pkg::DIFF_W'(-side_reg[0].dv_y)
                                                    : side_reg[0].dv_y;
        pd_x  = (dvm_x * c_reg) >> FRAC_BITS;
        pd_y  = (dvm_y * c_reg) >> FRAC_BITS;
        side_s2.damp_x = dsf_pkg::sat_mag(pd_x, side_reg[0].dv_x[dsf_pkg::DIFF_W-1]);
        side_s2.damp_y = dsf_pkg::sat_mag(pd_y, side_reg[0].dv_y[dsf_pkg::DIFF_W-1]);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            sum_reg <= sum_next;
    end

    // Square-root cell chain.
    logic [dsf_pkg::RAD_W-1:0]  rad_w  [NSQ+1];
    logic [dsf_pkg::REM_W-1:0]  rem_w  [NSQ+1];
    logic [dsf_pkg::ROOT_W-1:0] root_w [NSQ+1];

    assign rad_w[0]  = sum_reg;
    assign rem_w[0]  = '0;
    assign root_w[0] = '0;

    for (genvar j = 0; j < NSQ; j++)
    begin : g_sqrt
        dsf_sqrt_cell u_cell (
            .clk      (clk),
            .en       (adv),
            .rad      (rad_w[j]),
            .rem      (rem_w[j]),
            .root     (root_w[j]),
            .rad_reg  (rad_w[j+1]),
            .rem_reg  (rem_w[j+1]),
            .root_reg (root_w[j+1])
        );
    end

    // Extension stage: ext = |l| - rest and the saturated spring scale s.
    localparam int ROOT_W_E = dsf_pkg::ROOT_W + 1;
    logic signed [ROOT_W_E-1:0] ext;
    logic [dsf_pkg::DIFF_W-1:0] ext_mag;
    logic [dsf_pkg::PROD_W-1:0] pk;
    always_comb
    begin
        side_e     = side_reg[L_E-1];
        ext        = $signed({1'b0, root_w[NSQ]})
                   - $signed({{(ROOT_W_E-dsf_pkg::REG_W){1'b0}}, rest_reg});
        ext_mag    = ext[ROOT_W_E-1] ? dsf_pkg::DIFF_W'(-ext) : dsf_pkg::DIFF_W'(ext);
        pk         = (ext_mag * k_reg) >> FRAC_BITS;
        side_e.mag  = root_w[NSQ];
        side_e.s    = dsf_pkg::sat_mag(pk, !ext[ROOT_W_E-1]);
        side_e.hold = (ext == '0);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            side_reg[0]   <= side_s1;
            side_reg[1]   <= side_s2;
            side_reg[L_E] <= side_e;
            for (int i = 2; i < L_E; i++)
                side_reg[i] <= side_reg[i-1];
            for (int i = L_E + 1; i < NST; i++)
                side_reg[i] <= side_reg[i-1];
        end
    end

    // Divider cell chains for the unit vector, x and y side by side.
    logic [dsf_pkg::DREM_W-1:0] rx_w [QW+1];
    logic [dsf_pkg::DREM_W-1:0] ry_w [QW+1];
    logic [QW-1:0]              qx_w [QW+1];
    logic [QW-1:0]              qy_w [QW+1];

    assign rx_w[0] = dsf_pkg::DREM_W'(side_reg[L_E].dmag_x >> 1);
    assign ry_w[0] = dsf_pkg::DREM_W'(side_reg[L_E].dmag_y >> 1);
    assign qx_w[0] = '0;
    assign qy_w[0] = '0;

    for (genvar j = 0; j < QW; j++)
    begin : g_div
        logic nbx, nby;
        assign nbx = (j == 0) ? side_reg[L_E].dmag_x[0] : 1'b0;
        assign nby = (j == 0) ? side_reg[L_E].dmag_y[0] : 1'b0;

        dsf_div_cell #(.QW(QW)) u_cell_x (
            .clk     (clk),
            .en      (adv),
            .divisor (side_reg[L_E+j].mag),
            .rem     (rx_w[j]),
            .nbit    (nbx),
            .quo     (qx_w[j]),
            .rem_reg (rx_w[j+1]),
            .quo_reg (qx_w[j+1])
        );
        dsf_div_cell #(.QW(QW)) u_cell_y (
            .clk     (clk),
            .en      (adv),
            .divisor (side_reg[L_E+j].mag),
            .rem     (ry_w[j]),
            .nbit    (nby),
            .quo     (qy_w[j]),
            .rem_reg (ry_w[j+1]),
            .quo_reg (qy_w[j+1])
        );
    end

    // Spring product stage: |s| * u, scaled back; a zero length gives u = 0.
    dsf_pkg::side_t side_m;
    logic [QW-1:0]                 ux, uy;
    logic [dsf_pkg::TERM_W-1:0]    s_abs;
    logic [SP_W-1:0]               px, py;
    logic [dsf_pkg::TERM_W-1:0]    spx_reg, spy_reg;
    logic                          sgx_reg, sgy_reg;
    always_comb
    begin
        side_m = side_reg[L_M-1];
        ux     = (side_m.mag == '0) ? '0 : qx_w[QW];
        uy     = (side_m.mag == '0) ? '0 : qy_w[QW];
        s_abs  = side_m.s[dsf_pkg::TERM_W-1] ? (~side_m.s + 1'b1) : side_m.s;
        px     = (s_abs * ux) >> FRAC_BITS;
        py     = (s_abs * uy) >> FRAC_BITS;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            spx_reg <= px[dsf_pkg::TERM_W-1:0];
            spy_reg <= py[dsf_pkg::TERM_W-1:0];
            sgx_reg <= side_m.s[dsf_pkg::TERM_W-1] ^ side_m.neg_x;
            sgy_reg <= side_m.s[dsf_pkg::TERM_W-1] ^ side_m.neg_y;
        end
    end

    // Final stage: spring minus damping, saturated to 32 bits.
    localparam int F_W = dsf_pkg::TERM_W + 2;
    dsf_pkg::side_t    side_f;
    logic signed [F_W-1:0] fx, fy;
    logic signed [dsf_pkg::IN_W-1:0] fx_sat, fy_sat;
    logic signed [F_W-1:0] spx_s, spy_s;

    function automatic logic signed [dsf_pkg::IN_W-1:0] sat32(input logic signed [F_W-1:0] v);
        if (v > $signed(F_W'(32'h7FFF_FFFF)))
            sat32 = 32'sh7FFF_FFFF;
        else if (v < -$signed(F_W'(33'h0_8000_0000)))
            sat32 = 32'sh8000_0000;
        else
            sat32 = v[dsf_pkg::IN_W-1:0];
    endfunction

    always_comb
    begin
        side_f = side_reg[L_M];
        spx_s  = sgx_reg ? -$signed({2'b00, spx_reg}) : $signed({2'b00, spx_reg});
        spy_s  = sgy_reg ? -$signed({2'b00, spy_reg}) : $signed({2'b00, spy_reg});
        fx     = spx_s - F_W'(side_f.damp_x);
        fy     = spy_s - F_W'(side_f.damp_y);
        fx_sat = sat32(fx);
        fy_sat = sat32(fy);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid <= 1'b0;
        else if (adv)
            out_valid <= valid_reg[NST-1];
    end

    // An item whose length equals the rest length carries no force at all.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            force_x <= side_f.hold ? '0 : fx_sat;
            force_y <= side_f.hold ? '0 : fy_sat;
            applied <= !side_f.hold;
        end
    end

    a_no_force: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !applied |-> force_x == 0 && force_y == 0)
        else $error("cleared flag with nonzero force");

    a_enter: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> valid_reg[0])
        else $error("accepted word lost at pipe entry");

    a_empty_out: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> !in_stall)
        else $error("input stalled with empty output register");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(valid_reg))
        else $error("pipe moved under stall");

endmodule
`default_nettype wire

/* hw/rtl/dsf_sqrt_cell.sv */
`default_nettype none
// One bit of a digit-by-digit integer square root.
module dsf_sqrt_cell (
    input  wire logic                            clk,
    input  wire logic                            en,
    input  wire logic [dsf_pkg::RAD_W-1:0]       rad,
    input  wire logic [dsf_pkg::REM_W-1:0]       rem,
    input  wire logic [dsf_pkg::ROOT_W-1:0]      root,
    output logic      [dsf_pkg::RAD_W-1:0]       rad_reg,
    output logic      [dsf_pkg::REM_W-1:0]       rem_reg,
    output logic      [dsf_pkg::ROOT_W-1:0]      root_reg
);
    logic [dsf_pkg::REM_W+1:0] cur;
    logic [dsf_pkg::REM_W+1:0] trial;
    logic                      ge;

    always_comb
    begin
        cur   = {rem, rad[dsf_pkg::RAD_W-1 -: 2]};
        trial = {2'b00, root, 2'b01};
        ge    = (cur >= trial);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rad_reg  <= {rad[dsf_pkg::RAD_W-3:0], 2'b00};
            rem_reg  <= ge ? dsf_pkg::REM_W'(cur - trial) : cur[dsf_pkg::REM_W-1:0];
            root_reg <= {root[dsf_pkg::ROOT_W-2:0], ge};
        end
    end
endmodule
`default_nettype wire

/* hw/rtl/dsf_div_cell.sv */
`default_nettype none
// One quotient bit of a restoring divider.
module dsf_div_cell #(
    parameter int QW = 17
) (
    input  wire logic                          clk,
    input  wire logic                          en,
    input  wire logic [dsf_pkg::ROOT_W-1:0]    divisor,
    input  wire logic [dsf_pkg::DREM_W-1:0]    rem,
    input  wire logic                          nbit,
    input  wire logic [QW-1:0]                 quo,
    output logic      [dsf_pkg::DREM_W-1:0]    rem_reg,
    output logic      [QW-1:0]                 quo_reg
);
    logic [dsf_pkg::DREM_W:0] cur;
    logic                     ge;

    always_comb
    begin
        cur = {rem, nbit};
        ge  = (cur >= {2'b00, divisor});
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg <= ge ? dsf_pkg::DREM_W'(cur - {2'b00, divisor})
                          : cur[dsf_pkg::DREM_W-1:0];
            quo_reg <= {quo[QW-2:0], ge};
        end
    end
endmodule
`default_nettype wire

/* verif/tb_damped_spring_force_top.sv */
`default_nettype none
module tb_damped_spring_force_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FB        = 16;
    localparam int LATENCY   = FB + 40;
    localparam int CYCLE_CAP = 400000;
    localparam int N_RANDOM  = 1450;
    localparam longint TERM_LIM = 64'sh00_FFFF_FFFF_FF;

    // A force result as the block reports it.
    typedef struct packed {
        logic signed [31:0] fx;
        logic signed [31:0] fy;
        logic               app;
    } force_t;

    // One spring word on the input channel.
    typedef struct packed {
        logic signed [31:0] ax;
        logic signed [31:0] ay;
        logic signed [31:0] bx;
        logic signed [31:0] by;
        logic signed [31:0] avx;
        logic signed [31:0] avy;
        logic signed [31:0] bvx;
        logic signed [31:0] bvy;
    } spring_t;

    // Directed row: a spring word plus an optional hand-written force.
    typedef struct {
        spring_t w;
        bit      known;
        force_t  f;
    } row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    spring_t drv = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic signed [31:0] force_x, force_y;
    logic applied;
    logic cfg_we = 1'b0;
    logic [1:0] cfg_index = dsf_pkg::REG_SPRING_K;
    logic [dsf_pkg::REG_W-1:0] cfg_data = '0;

    // Local copy of the spring registers.
    longint unsigned k_reg = 65536, c_reg = 0, rest_reg = 65536;

    force_t expected_forces[$];
    int errors = 0;
    int cycles = 0;
    bit out_idle_on = 1'b1;

    always #5 clk = ~clk;

    damped_spring_force_top i_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .a_pos_x(drv.ax), .a_pos_y(drv.ay), .b_pos_x(drv.bx), .b_pos_y(drv.by),
        .a_vel_x(drv.avx), .a_vel_y(drv.avy), .b_vel_x(drv.bvx), .b_vel_y(drv.bvy),
        .out_valid(out_valid), .out_stall(out_stall),
        .force_x(force_x), .force_y(force_y), .applied(applied),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    function automatic longint clamp(longint v, longint lim);
        if (v > lim) return lim;
        if (v < -lim - 1) return -lim - 1;
        return v;
    endfunction

    // trunc(a * b / 2^FB); operands stay within 41 and 31 bits, so 128 bits is ample.
    function automatic longint scale_trunc(longint a, longint unsigned b);
        logic [127:0] p;
        longint unsigned m;
        m = (a < 0) ? longint'(-a) : longint'(a);
        p = (128'(m) * 128'(b)) >> FB;
        return (a < 0) ? -longint'(p[63:0]) : longint'(p[63:0]);
    endfunction

    // Integer square root of the squared spring length, bit by bit.
    function automatic longint unsigned length_floor(logic [65:0] sq);
        logic [67:0] r, t;
        r = '0;
        for (int b = 33; b >= 0; b--) begin
            t = r | (68'd1 << b);
            if (t * t <= 68'(sq))
                r = t;
        end
        return r[63:0];
    endfunction

    // The force on body a for one spring word.
    function automatic force_t spring_force(spring_t w);
        longint dx, dy, dvx, dvy, ext, s, fx, fy, ux, uy;
        longint unsigned len, mx, my;
        force_t f;
        dx  = longint'(w.ax)  - longint'(w.bx);
        dy  = longint'(w.ay)  - longint'(w.by);
        dvx = longint'(w.avx) - longint'(w.bvx);
        dvy = longint'(w.avy) - longint'(w.bvy);
        mx  = (dx < 0) ? -dx : dx;
        my  = (dy < 0) ? -dy : dy;
        len = length_floor(66'(mx) * 66'(mx) + 66'(my) * 66'(my));
        ext = longint'(len) - longint'(rest_reg);
        if (ext == 0)
            return '0;
        s  = clamp(-scale_trunc(ext, k_reg), TERM_LIM);
        ux = (len == 0) ? 0 : longint'((mx << FB) / len);
        uy = (len == 0) ? 0 : longint'((my << FB) / len);
        fx = scale_trunc(s, ux) * ((dx < 0) ? -1 : 1)
             - clamp(scale_trunc(dvx, c_reg), TERM_LIM);
        fy = scale_trunc(s, uy) * ((dy < 0) ? -1 : 1)
             - clamp(scale_trunc(dvy, c_reg), TERM_LIM);
        f.fx  = 32'(clamp(fx, 64'sh7FFF_FFFF));
        f.fy  = 32'(clamp(fy, 64'sh7FFF_FFFF));
        f.app = 1'b1;
        return f;
    endfunction

    task automatic report_mismatch(string what, force_t got, force_t want);
        errors++;
        $display("mismatch %s: got fx=%0d fy=%0d app=%0b, expected fx=%0d fy=%0d app=%0b",
                 what, got.fx, got.fy, got.app, want.fx, want.fy, want.app);
    endtask

    // Cycle counter and a hard stop if the pipe hangs.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_CAP)
        begin
            $display("tb_damped_spring_force_top: FAIL");
            $finish;
        end
    end

    // Result side: check at the rising edge, pick a new stall at the falling edge.
    always @(posedge clk)
    begin
        force_t got, want;
        if (rst_n && out_valid && !out_stall)
        begin
            got = '{force_x, force_y, applied};
            if (expected_forces.size() == 0)
                report_mismatch("unexpected word", got, '0);
            else
            begin
                want = expected_forces.pop_front();
                if (got.fx !== want.fx || got.fy !== want.fy || got.app !== want.app)
                    report_mismatch("force", got, want);
            end
        end
    end

    always @(negedge clk)
        out_stall <= out_idle_on ? ($urandom_range(0, 99) < 32) : 1'b0;

    // Write one register while the pipe is empty and mirror it locally.
    task automatic write_reg(dsf_pkg::reg_index_t idx, longint unsigned val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val[dsf_pkg::REG_W-1:0];
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            dsf_pkg::REG_SPRING_K: k_reg    = val[dsf_pkg::REG_W-1:0];
            dsf_pkg::REG_DAMPING:  c_reg    = val[dsf_pkg::REG_W-1:0];
            default:               rest_reg = val[dsf_pkg::REG_W-1:0];
        endcase
    endtask

    // Take the input idle, wait until every expected word has come back,
    // then let the pipe drain.
    task automatic drain_pipe();
        in_valid <= 1'b0;
        while (expected_forces.size() != 0)
            @(negedge clk);
        repeat (LATENCY + 4) @(negedge clk);
    endtask

    // Present one word from the falling edge and hold it until accepted.
    // The word stays on the port after acceptance until the next word or an idle
    // cycle replaces it at the same falling edge.
    task automatic send_word(spring_t w, force_t want, bit gap_ok);
        while (gap_ok && $urandom_range(0, 99) < 32)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        drv      <= w;
        in_valid <= 1'b1;
        expected_forces = {expected_forces, want};
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    function automatic logic [31:0] rand_field();
        case ($urandom_range(0, 5))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'($signed($urandom_range(0, 8 << FB)) - (4 << FB));
            default: return $urandom();
        endcase
    endfunction

    function automatic spring_t rand_word();
        spring_t w;
        w.ax = rand_field(); w.ay = rand_field();
        w.avx = rand_field(); w.avy = rand_field();
        w.bvx = rand_field(); w.bvy = rand_field();
        // Half random springs, some modest, some of zero length, some exactly at rest length.
        case ($urandom_range(0, 7))
            0:
            begin
                w.bx = w.ax - 32'(rest_reg);
                w.by = w.ay;
            end
            1:
            begin
                w.bx = w.ax;
                w.by = w.ay;
            end
            2, 3:
            begin
                w.bx = w.ax + 32'($signed($urandom_range(0, 16 << FB)) - (8 << FB));
                w.by = w.ay + 32'($signed($urandom_range(0, 16 << FB)) - (8 << FB));
            end
            default:
            begin
                w.bx = rand_field();
                w.by = rand_field();
            end
        endcase
        return w;
    endfunction

    row_t rows[$];

    initial
    begin
        row_t r;
        spring_t w;
        longint unsigned settings[5][3];

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Rest length 1.0 exactly along x and along y: no force, flag clear.
        r.known = 1; r.f = '0;
        r.w = '{32'sh0001_0000, 0, 0, 0, 32'sh0005_0000, 0, 0, 0}; rows = {rows, r};
        r.w = '{0, 32'shFFFF_0000, 0, 0, 0, 0, 32'sh7FFF_FFFF, 0}; rows = {rows, r};
        // Stretched by 1.0 along x with k = 1.0: pulls back by one.
        r.f = '{32'shFFFF_0000, 0, 1'b1};
        r.w = '{32'sh0002_0000, 0, 0, 0, 0, 0, 0, 0}; rows = {rows, r};
        // Zero-length spring, no damping: unit vector is zero.
        r.f = '{0, 0, 1'b1};
        r.w = '{32'sh1234_5678, 32'sh1234_5678, 32'sh1234_5678, 32'sh1234_5678,
                0, 0, 0, 0};
        rows = {rows, r};
        // Extremes and other words, checked by the predictor.
        r.known = 0;
        r.w = '{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000,
                32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF};
        rows = {rows, r};
        r.w = '{32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000};
        rows = {rows, r};
        r.w = '{32'shFFFF_FFFF, 0, 0, 32'sh0000_0001, -1, -1, -1, -1}; rows = {rows, r};
        r.w = '{0, 32'sh0000_8000, 0, 0, 32'sh0003_0000, 0, 0, 32'sh0003_0000};
        rows = {rows, r};
        r.w = '{32'sh0003_0000, 32'sh0004_0000, 0, 0, 0, 0, 0, 0}; rows = {rows, r};

        foreach (rows[i])
            send_word(rows[i].w, rows[i].known ? rows[i].f : spring_force(rows[i].w), 0);
        drain_pipe();

        // Register settings: damping on, extremes, all zero, stiffer, least k, zero rest.
        settings = '{'{65536, 32768, 65536},
                     '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF},
                     '{0, 0, 0},
                     '{3 << FB, 1 << (FB - 2), 2 << FB},
                     '{1, 32'h7FFF_FFFF, 0}};

        for (int p = 0; p < 5; p++)
        begin
            write_reg(dsf_pkg::REG_SPRING_K, settings[p][0]);
            write_reg(dsf_pkg::REG_DAMPING,  settings[p][1]);
            write_reg(dsf_pkg::REG_REST_LEN, settings[p][2]);
            // Zero-length spring with zero rest length: no force.
            if (p == 2)
            begin
                w = '{5, 6, 5, 6, 32'sh0001_0000, 0, 0, 0};
                send_word(w, '0, 0);
            end
            out_idle_on = (p != 3);
            for (int n = 0; n < N_RANDOM / 5; n++)
            begin
                w = rand_word();
                send_word(w, spring_force(w), p != 3);
                // Hold the sender off until everything in flight has returned.
                if (n == 100)
                begin
                    in_valid <= 1'b0;
                    while (expected_forces.size() != 0)
                        @(negedge clk);
                end
            end
            out_idle_on = 1'b1;
            drain_pipe();
        end

        if (errors == 0 && expected_forces.size() == 0)
            $display("tb_damped_spring_force_top: PASS");
        else
            $display("tb_damped_spring_force_top: FAIL");
        $finish;
    end
endmodule
`default_nettype wire
